// ----- hdl/bdft_pkg.sv -----
// ----------------------------------------------------------------------------
// bdft_pkg
// Shared constants, codes and the command type of the block dirty-flag table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdft_pkg;

  localparam int MAX_BLOCKS_DEF = 15;
  localparam int SUBS_PER_BLOCK = 2;

  localparam int BLK_W      = 4;
  localparam int CNT_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int BASE_W     = BLK_W + 1;
  localparam int RES_W      = 1;
  localparam int QDEPTH     = 2;
  localparam int LANES      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_Z = 2'd2;

  localparam logic REQ_QUERY  = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  localparam logic [1:0] MODE_BIT_UNSHIFTED = 2'b01;
  localparam logic [1:0] MODE_BIT_SHIFTED   = 2'b10;
  localparam logic [1:0] MARK_RESET         = 2'b01;
  localparam logic [2*LANES-1:0] ROW_RESET  = {LANES{MARK_RESET}};

  typedef struct packed {
    logic              upd;
    logic              sel;
    logic              chg;
    logic [BASE_W-1:0] x0;
    logic [BASE_W-1:0] y0;
    logic [BASE_W-1:0] z0;
  } bdft_cmd_t;

endpackage

// ----- hdl/block_dirty_flag_table.sv -----
// ----------------------------------------------------------------------------
// block_dirty_flag_table
// Each request runs as eight serial read-modify-write steps on the single
// port pair of the mark memory; further requests wait in the queues.
// Reset: synchronous; a clearing pass over all (2*(MAX_BLOCKS_PER_AXIS+1))^3/8
// mark rows (4096 by default) sets every mark to 01, with in_full held high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_dirty_flag_table
  import bdft_pkg::*;
#(
  parameter int MAX_BLOCKS_PER_AXIS = MAX_BLOCKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_req_type,
  input  logic [BLK_W-1:0]      in_block_x,
  input  logic [BLK_W-1:0]      in_block_y,
  input  logic [BLK_W-1:0]      in_block_z,
  input  logic                  in_shifted,
  input  logic                  in_changed,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic                  out_any_changed,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SUB_AXIS = SUBS_PER_BLOCK * (MAX_BLOCKS_PER_AXIS + 1);
  localparam int DEPTH    = SUB_AXIS * SUB_AXIS * SUB_AXIS;
  localparam int LW       = $clog2(DEPTH);
  localparam int NW       = $clog2(SUB_AXIS + 1);
  localparam int CMD_W    = $bits(bdft_cmd_t);

  function automatic logic [NW-1:0] sub_size(input logic [CNT_W-1:0] c);
    logic [NW-1:0] cc;
    if (int'(c) > MAX_BLOCKS_PER_AXIS) begin
      cc = NW'(MAX_BLOCKS_PER_AXIS);
    end else begin
      cc = NW'(c);
    end
    return NW'(SUBS_PER_BLOCK) * (cc + NW'(1));
  endfunction

  logic [NW-1:0] nx_r, ny_r, nz_r;
  logic [LW-1:0] plane_r;
  logic          cfg_wr;

  logic             clearing;
  logic             cmd_full, cmd_push, cmd_empty, cmd_pop;
  bdft_cmd_t        cmd_in, cmd_out;
  logic [CMD_W-1:0] cmd_dout;
  logic             res_full, res_push, res_any;
  logic [RES_W-1:0] res_dout;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r <= sub_size(CNT_W'(MAX_BLOCKS_DEF));
      ny_r <= sub_size(CNT_W'(MAX_BLOCKS_DEF));
      nz_r <= sub_size(CNT_W'(MAX_BLOCKS_DEF));
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_BLOCKS_X: nx_r <= sub_size(cfg_data);
        REG_BLOCKS_Y: ny_r <= sub_size(cfg_data);
        REG_BLOCKS_Z: nz_r <= sub_size(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    plane_r <= LW'(nx_r) * LW'(ny_r);
  end

  bdft_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_req_type (in_req_type),
    .in_block_x  (in_block_x),
    .in_block_y  (in_block_y),
    .in_block_z  (in_block_z),
    .in_shifted  (in_shifted),
    .in_changed  (in_changed),
    .clearing    (clearing),
    .cmd_full    (cmd_full),
    .cmd_push    (cmd_push),
    .cmd_data    (cmd_in)
  );

  bdft_fifo #(
    .W (CMD_W)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .full  (cmd_full),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .dout  (cmd_dout)
  );

  assign cmd_out = bdft_cmd_t'(cmd_dout);

  bdft_back #(
    .MAX_BLOCKS_PER_AXIS (MAX_BLOCKS_PER_AXIS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .nx              (nx_r),
    .ny              (ny_r),
    .nz              (nz_r),
    .plane           (plane_r),
    .clearing        (clearing),
    .cmd_empty       (cmd_empty),
    .cmd_pop         (cmd_pop),
    .cmd_data        (cmd_out),
    .res_full        (res_full),
    .res_push        (res_push),
    .res_any_changed (res_any)
  );

  bdft_fifo #(
    .W (RES_W)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .din   (res_any),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (res_dout)
  );

  assign out_any_changed = res_dout[0];

endmodule

// ----- hdl/bdft_fifo.sv -----
// ----------------------------------------------------------------------------
// bdft_fifo
// Small synchronous queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdft_fifo
  import bdft_pkg::*;
#(
  parameter int W = RES_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] dout
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  logic [W-1:0]  mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- hdl/bdft_front.sv -----
// ----------------------------------------------------------------------------
// bdft_front
// Input stage: takes requests and turns them into sub-block commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdft_front
  import bdft_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic             in_req_type,
  input  logic [BLK_W-1:0] in_block_x,
  input  logic [BLK_W-1:0] in_block_y,
  input  logic [BLK_W-1:0] in_block_z,
  input  logic             in_shifted,
  input  logic             in_changed,
  input  logic             clearing,
  input  logic             cmd_full,
  output logic             cmd_push,
  output bdft_cmd_t        cmd_data
);

  logic      f_vld_r, f_vld_nxt;
  bdft_cmd_t cmd_r;
  logic      accept;

  assign in_full  = clearing || (f_vld_r && cmd_full);
  assign accept   = in_push && !in_full;
  assign cmd_push = f_vld_r && !cmd_full;
  assign cmd_data = cmd_r;

  always_comb begin
    f_vld_nxt = f_vld_r;
    if (accept) begin
      f_vld_nxt = 1'b1;
    end else if (cmd_push) begin
      f_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
  end

  // group origin: twice the block coordinate, plus one when unshifted
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.upd <= (in_req_type == REQ_UPDATE);
      cmd_r.sel <= in_shifted;
      cmd_r.chg <= in_changed;
      cmd_r.x0  <= {in_block_x, ~in_shifted};
      cmd_r.y0  <= {in_block_y, ~in_shifted};
      cmd_r.z0  <= {in_block_z, ~in_shifted};
    end
  end

endmodule

// ----- hdl/bdft_back.sv -----
// ----------------------------------------------------------------------------
// bdft_back
// Execution stage: clears the mark memory after reset, then walks the eight
// sub-blocks of each command with pipelined read-modify-write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdft_back
  import bdft_pkg::*;
#(
  parameter  int MAX_BLOCKS_PER_AXIS = MAX_BLOCKS_DEF,
  localparam int SUB_AXIS = SUBS_PER_BLOCK * (MAX_BLOCKS_PER_AXIS + 1),
  localparam int DEPTH    = SUB_AXIS * SUB_AXIS * SUB_AXIS,
  localparam int LW       = $clog2(DEPTH),
  localparam int NW       = $clog2(SUB_AXIS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [NW-1:0] nx,
  input  logic [NW-1:0] ny,
  input  logic [NW-1:0] nz,
  input  logic [LW-1:0] plane,
  output logic          clearing,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  input  bdft_cmd_t     cmd_data,
  input  logic          res_full,
  output logic          res_push,
  output logic          res_any_changed
);

  localparam int RW   = LW - 3;
  localparam int ROWS = DEPTH / LANES;
  localparam int CW   = (NW > 6) ? NW : 6;
  localparam int DW   = 2 * LANES;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BASE1,
    ST_BASE2,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [RW-1:0] clr_row_r, clr_row_nxt;
  logic [3:0]    k_r, k_nxt;
  logic          any_r, any_nxt;
  logic          p1_vld_r, p1_vld_nxt;
  logic          wr_done_r;

  bdft_cmd_t     cmd_r;
  logic [LW-1:0] t_r;
  logic [LW-1:0] base_r;
  logic          p1_in_r;
  logic [RW-1:0] p1_row_r;
  logic [2:0]    p1_lane_r;
  logic [DW-1:0] rdata_r;
  logic [RW-1:0] wr_row_r;
  logic [DW-1:0] wr_data_r;
  logic [DW-1:0] mem [ROWS];

  logic          issue, in_rng, hit, clear, rmw_we, mem_we;
  logic [CW-1:0] xs, ys, zs;
  logic [LW-1:0] addr;
  logic [RW-1:0] rd_row, mem_wrow;
  logic [DW-1:0] merged, wrow_data, mem_wdata;
  logic [1:0]    entry, this_bit, new_entry;

  assign issue = (state_r == ST_RUN) && !k_r[3];

  assign xs     = CW'(cmd_r.x0) + CW'(k_r[0]);
  assign ys     = CW'(cmd_r.y0) + CW'(k_r[1]);
  assign zs     = CW'(cmd_r.z0) + CW'(k_r[2]);
  assign in_rng = (xs < CW'(nx)) && (ys < CW'(ny)) && (zs < CW'(nz));
  assign addr   = base_r + LW'(k_r[0]) + (k_r[1] ? LW'(nx) : '0) + (k_r[2] ? plane : '0);
  assign rd_row = addr[LW-1:3];

  // row written on the same edge as the read is not yet in the read data
  assign merged    = (wr_done_r && (wr_row_r == p1_row_r)) ? wr_data_r : rdata_r;
  assign entry     = merged[{p1_lane_r, 1'b0} +: 2];
  assign this_bit  = cmd_r.sel ? MODE_BIT_SHIFTED : MODE_BIT_UNSHIFTED;
  assign new_entry = (entry & ~this_bit) | (cmd_r.chg ? this_bit : 2'b00);
  assign hit       = p1_vld_r && p1_in_r && (entry != 2'b00);
  assign rmw_we    = (state_r == ST_RUN) && p1_vld_r && p1_in_r && cmd_r.upd;

  always_comb begin
    wrow_data = merged;
    wrow_data[{p1_lane_r, 1'b0} +: 2] = new_entry;
  end

  assign clear     = (state_r == ST_CLEAR);
  assign clearing  = clear;
  assign mem_we    = clear || rmw_we;
  assign mem_wrow  = clear ? clr_row_r : p1_row_r;
  assign mem_wdata = clear ? ROW_RESET : wrow_data;

  assign res_any_changed = cmd_r.upd ? 1'b0 : any_r;

  always_comb begin
    state_nxt   = state_r;
    clr_row_nxt = clr_row_r;
    k_nxt       = k_r;
    any_nxt     = any_r;
    p1_vld_nxt  = issue;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        if (clr_row_r == RW'(ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_row_nxt = clr_row_r + RW'(1);
        end
      end
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop   = 1'b1;
          state_nxt = ST_BASE1;
        end
      end
      ST_BASE1: begin
        state_nxt = ST_BASE2;
      end
      ST_BASE2: begin
        k_nxt     = '0;
        any_nxt   = 1'b0;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (hit) begin
          any_nxt = 1'b1;
        end
        if (issue) begin
          k_nxt = k_r + 4'd1;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_row_r <= '0;
      k_r       <= '0;
      any_r     <= 1'b0;
      p1_vld_r  <= 1'b0;
      wr_done_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_row_r <= clr_row_nxt;
      k_r       <= k_nxt;
      any_r     <= any_nxt;
      p1_vld_r  <= p1_vld_nxt;
      wr_done_r <= mem_we;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r <= cmd_data;
    end
    if (state_r == ST_BASE1) begin
      t_r <= LW'(cmd_r.z0) * LW'(ny) + LW'(cmd_r.y0);
    end
    if (state_r == ST_BASE2) begin
      base_r <= t_r * LW'(nx) + LW'(cmd_r.x0);
    end
    if (issue) begin
      p1_in_r   <= in_rng;
      p1_row_r  <= rd_row;
      p1_lane_r <= addr[2:0];
    end
    wr_row_r  <= mem_wrow;
    wr_data_r <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wrow] <= mem_wdata;
    end
    rdata_r <= mem[rd_row];
  end

endmodule
